FILE: rtl/sfx_voice_channel_allocator_defines.svh
// ----------------------------------------------------------------------------
// sfx_voice_channel_allocator_defines
// assertion macros shared by the allocator checker
// ----------------------------------------------------------------------------
`ifndef SFX_VOICE_CHANNEL_ALLOCATOR_DEFINES_SVH
`define SFX_VOICE_CHANNEL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFX_VCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfx_vca check failed");

// next-cycle implication, sampled on clk, off during reset
`define SFX_VCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfx_vca check failed");

`endif

FILE: rtl/sfx_vca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_vca_pkg
// shared constants of the sound-effect voice channel allocator
// ----------------------------------------------------------------------------
package sfx_vca_pkg;

  localparam int CHANNELS_DEFAULT = 4;
  localparam int PRIO_W           = 8;
  localparam int PREF_W           = 3;
  localparam int STAGE_W          = 3;
  localparam int REG_IDX_W        = 2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_PREFERRED = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RESERVED  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEAL     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MUSIC_PRI = 2'd3;

  // preferred channel reset value: automatic
  localparam logic [PREF_W-1:0] PREF_AUTO = 3'd4;

  // how the channel was won
  localparam logic [STAGE_W-1:0] STAGE_PREFERRED = 3'd0;
  localparam logic [STAGE_W-1:0] STAGE_RESERVED  = 3'd1;
  localparam logic [STAGE_W-1:0] STAGE_SILENT    = 3'd2;
  localparam logic [STAGE_W-1:0] STAGE_MUSIC     = 3'd3;
  localparam logic [STAGE_W-1:0] STAGE_EFFECT    = 3'd4;

endpackage

FILE: rtl/sfx_vca_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_vca_regs
// configuration registers written through the cfg channel
// ----------------------------------------------------------------------------
module sfx_vca_regs #(
  parameter int CHANNELS = sfx_vca_pkg::CHANNELS_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_valid,
  input  logic [sfx_vca_pkg::REG_IDX_W-1:0]          cfg_index,
  input  logic [sfx_vca_pkg::PRIO_W*CHANNELS-1:0]    cfg_data,
  output logic [sfx_vca_pkg::PREF_W-1:0]             pref_chan,
  output logic [CHANNELS-1:0]                        reserved_mask,
  output logic [CHANNELS-1:0]                        steal_mask,
  output logic [sfx_vca_pkg::PRIO_W*CHANNELS-1:0]    music_priorities
);
  import sfx_vca_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      pref_chan         <= PREF_AUTO;
      reserved_mask     <= '0;
      steal_mask        <= '1;
      music_priorities  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PREFERRED: pref_chan         <= cfg_data[PREF_W-1:0];
        REG_RESERVED:  reserved_mask     <= cfg_data[CHANNELS-1:0];
        REG_STEAL:     steal_mask        <= cfg_data[CHANNELS-1:0];
        REG_MUSIC_PRI: music_priorities  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/sfx_vca_minpick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_vca_minpick
// lowest-priority candidate, ties to preferred, then reserved, then low index
// ----------------------------------------------------------------------------
module sfx_vca_minpick #(
  parameter int CHANNELS = sfx_vca_pkg::CHANNELS_DEFAULT,
  parameter int CH_W     = $clog2(CHANNELS)
) (
  input  logic [CHANNELS-1:0]                     cand,
  input  logic [sfx_vca_pkg::PRIO_W*CHANNELS-1:0] prios,
  input  logic [CHANNELS-1:0]                     pref_hit,
  input  logic [CHANNELS-1:0]                     reserved_mask,
  output logic                                    found,
  output logic [CH_W-1:0]                         idx,
  output logic [sfx_vca_pkg::PRIO_W-1:0]          prio
);
  import sfx_vca_pkg::*;

  // sort key: priority, not preferred, not reserved, index (smaller wins)
  localparam int KEY_W = PRIO_W + 2 + CH_W;

  logic [KEY_W-1:0] best;
  logic [KEY_W-1:0] key;

  always_comb begin
    found = 1'b0;
    best  = '1;
    key   = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      key = {prios[c*PRIO_W +: PRIO_W], ~pref_hit[c], ~reserved_mask[c], CH_W'(c)};
      if (cand[c] && (!found || key < best)) begin
        found = 1'b1;
        best  = key;
      end
    end
    idx  = best[CH_W-1:0];
    prio = best[KEY_W-1 -: PRIO_W];
  end

endmodule

FILE: rtl/sfx_vca_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_vca_arbiter
// five-step channel choice for one request
// ----------------------------------------------------------------------------
module sfx_vca_arbiter #(
  parameter int CHANNELS = sfx_vca_pkg::CHANNELS_DEFAULT,
  parameter int CH_W     = $clog2(CHANNELS)
) (
  input  logic [sfx_vca_pkg::PREF_W-1:0]          pref_chan,
  input  logic [CHANNELS-1:0]                     reserved_mask,
  input  logic [CHANNELS-1:0]                     steal_mask,
  input  logic [sfx_vca_pkg::PRIO_W*CHANNELS-1:0] music_priorities,
  input  logic [CHANNELS-1:0]                     effect_busy_mask,
  input  logic [CHANNELS-1:0]                     silent_mask,
  input  logic [CHANNELS-1:0]                     music_mask,
  input  logic [sfx_vca_pkg::PRIO_W*CHANNELS-1:0] effect_priorities,
  input  logic [sfx_vca_pkg::PRIO_W-1:0]          request_priority,
  output logic                                    granted,
  output logic [CH_W-1:0]                         channel,
  output logic [sfx_vca_pkg::STAGE_W-1:0]         stage
);
  import sfx_vca_pkg::*;

  logic [CHANNELS-1:0] free;
  logic [CHANNELS-1:0] pref_hit;
  logic [CHANNELS-1:0] res_cand;
  logic [CHANNELS-1:0] sil_cand;
  logic [CHANNELS-1:0] mus_cand;
  logic                pref_ok;
  logic                res_found;
  logic                sil_found;
  logic [CH_W-1:0]     pref_idx;
  logic [CH_W-1:0]     res_idx;
  logic [CH_W-1:0]     sil_idx;
  logic                mus_found;
  logic [CH_W-1:0]     mus_idx;
  logic [PRIO_W-1:0]   mus_prio;
  logic                eff_found;
  logic [CH_W-1:0]     eff_idx;
  logic [PRIO_W-1:0]   eff_prio;

  assign free     = ~effect_busy_mask;
  assign res_cand = free & reserved_mask;
  assign sil_cand = free & silent_mask;
  assign mus_cand = free & music_mask & steal_mask;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      pref_hit[c] = (pref_chan == PREF_W'(c));
    end
    pref_ok  = |pref_hit;
    pref_idx = pref_chan[CH_W-1:0];
  end

  // lowest set bit of each free mask
  always_comb begin
    res_found = 1'b0;
    sil_found = 1'b0;
    res_idx   = '0;
    sil_idx   = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (res_cand[c]) begin
        res_found = 1'b1;
        res_idx   = CH_W'(c);
      end
      if (sil_cand[c]) begin
        sil_found = 1'b1;
        sil_idx   = CH_W'(c);
      end
    end
  end

  sfx_vca_minpick #(.CHANNELS(CHANNELS), .CH_W(CH_W)) u_music (
    .cand          (mus_cand),
    .prios         (music_priorities),
    .pref_hit      (pref_hit),
    .reserved_mask (reserved_mask),
    .found         (mus_found),
    .idx           (mus_idx),
    .prio          (mus_prio)
  );

  sfx_vca_minpick #(.CHANNELS(CHANNELS), .CH_W(CH_W)) u_effect (
    .cand          (effect_busy_mask),
    .prios         (effect_priorities),
    .pref_hit      (pref_hit),
    .reserved_mask (reserved_mask),
    .found         (eff_found),
    .idx           (eff_idx),
    .prio          (eff_prio)
  );

  always_comb begin
    granted = 1'b0;
    channel = '0;
    stage   = STAGE_PREFERRED;
    if (pref_ok && free[pref_idx] && (reserved_mask[pref_idx] || silent_mask[pref_idx])) begin
      granted = 1'b1;
      channel = pref_idx;
      stage   = STAGE_PREFERRED;
    end else if (res_found) begin
      granted = 1'b1;
      channel = res_idx;
      stage   = STAGE_RESERVED;
    end else if (sil_found) begin
      granted = 1'b1;
      channel = sil_idx;
      stage   = STAGE_SILENT;
    end else if (mus_found) begin
      granted = 1'b1;
      channel = mus_idx;
      stage   = STAGE_MUSIC;
    end else if (eff_found && request_priority >= eff_prio) begin
      granted = 1'b1;
      channel = eff_idx;
      stage   = STAGE_EFFECT;
    end
  end

endmodule

FILE: rtl/sfx_voice_channel_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_voice_channel_allocator
// picks the voice channel for a new sound effect from a status snapshot
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid/in_ready): one word is a status snapshot of all
//   channels plus the priority of the effect asking for a channel
// - output channel (out_valid/out_ready): one word per input word with
//   granted, channel and stage (how the channel was won)
// - cfg channel (cfg_valid/cfg_ready): register writes by index; always
//   ready; the user writes only while no request is in flight, unenforced
// - path: an accepted word sits in the input register, is decided and
//   loaded into the result register when that is free, and leaves from it
//   once out_ready is high
// - throughput: one word per cycle while the receiver takes results; the
//   whole decision sits between the input register and the result register
// - a stalled receiver holds the result register; the input register still
//   takes one more word, and in_ready drops only when both are full
// - reset clears both valid flags and loads the register reset values:
//   automatic preference, no reserved channels, all music stealable
// ----------------------------------------------------------------------------
module sfx_voice_channel_allocator #(
  parameter int CHANNELS = sfx_vca_pkg::CHANNELS_DEFAULT,
  parameter int CH_W     = $clog2(CHANNELS)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [sfx_vca_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [sfx_vca_pkg::PRIO_W*CHANNELS-1:0] cfg_data,
  // request words
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [CHANNELS-1:0]                     effect_busy_mask,
  input  logic [CHANNELS-1:0]                     silent_mask,
  input  logic [CHANNELS-1:0]                     music_mask,
  input  logic [sfx_vca_pkg::PRIO_W*CHANNELS-1:0] effect_priorities,
  input  logic [sfx_vca_pkg::PRIO_W-1:0]          request_priority,
  // result words
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    granted,
  output logic [CH_W-1:0]                         channel,
  output logic [sfx_vca_pkg::STAGE_W-1:0]         stage
);
  import sfx_vca_pkg::*;

  // configuration
  logic [PREF_W-1:0]          pref_chan;
  logic [CHANNELS-1:0]        reserved_mask;
  logic [CHANNELS-1:0]        steal_mask;
  logic [PRIO_W*CHANNELS-1:0] music_priorities;

  // input register
  logic                       in_full;
  logic [CHANNELS-1:0]        req_busy;
  logic [CHANNELS-1:0]        req_silent;
  logic [CHANNELS-1:0]        req_music;
  logic [PRIO_W*CHANNELS-1:0] req_eprio;
  logic [PRIO_W-1:0]          req_prio;

  // decision
  logic                       granted_next;
  logic [CH_W-1:0]            channel_next;
  logic [STAGE_W-1:0]         stage_next;

  logic                       out_free;

  assign cfg_ready = 1'b1;

  // the result register frees up when empty or taken this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = !in_full || out_free;

  sfx_vca_regs #(.CHANNELS(CHANNELS)) u_regs (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pref_chan         (pref_chan),
    .reserved_mask     (reserved_mask),
    .steal_mask        (steal_mask),
    .music_priorities  (music_priorities)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_busy   <= effect_busy_mask;
      req_silent <= silent_mask;
      req_music  <= music_mask;
      req_eprio  <= effect_priorities;
      req_prio   <= request_priority;
    end
  end

  sfx_vca_arbiter #(.CHANNELS(CHANNELS), .CH_W(CH_W)) u_arb (
    .pref_chan         (pref_chan),
    .reserved_mask     (reserved_mask),
    .steal_mask        (steal_mask),
    .music_priorities  (music_priorities),
    .effect_busy_mask  (req_busy),
    .silent_mask       (req_silent),
    .music_mask        (req_music),
    .effect_priorities (req_eprio),
    .request_priority  (req_prio),
    .granted           (granted_next),
    .channel           (channel_next),
    .stage             (stage_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_full) begin
      granted <= granted_next;
      channel <= channel_next;
      stage   <= stage_next;
    end
  end

endmodule

FILE: rtl/sfx_vca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_vca_checker
// port-level checks on the allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "sfx_voice_channel_allocator_defines.svh"

module sfx_vca_checker #(
  parameter int CHANNELS = sfx_vca_pkg::CHANNELS_DEFAULT,
  parameter int CH_W     = $clog2(CHANNELS)
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            granted,
  input logic [CH_W-1:0]                 channel,
  input logic [sfx_vca_pkg::STAGE_W-1:0] stage
);
  import sfx_vca_pkg::*;

  // whole result word, for the hold check
  logic [CH_W+STAGE_W:0] result_word;

  assign result_word = {granted, channel, stage};

  // a refusal carries all-zero fields
  `SFX_VCA_ASSERT_NOW(a_refuse_zero, out_valid && !granted, channel == '0 && stage == STAGE_PREFERRED)

  // a grant names one of the five ways to win
  `SFX_VCA_ASSERT_NOW(a_stage_legal, out_valid && granted, stage <= STAGE_EFFECT)

  // a held result stays put
  `SFX_VCA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(result_word))

  // with the output draining, input is never blocked
  `SFX_VCA_ASSERT_NOW(a_no_block, out_ready, in_ready)

endmodule

bind sfx_voice_channel_allocator sfx_vca_checker #(
  .CHANNELS (CHANNELS),
  .CH_W     (CH_W)
) u_sfx_vca_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .granted   (granted),
  .channel   (channel),
  .stage     (stage)
);
